[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shorthand for clocked assertions, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ccfr_pkg.sv]
// ----------------------------------------------------------------------------
// ccfr_pkg
// Shared types, codes and constants of the checked frame receiver.
// ----------------------------------------------------------------------------
package ccfr_pkg;

  localparam int unsigned CountW = 9;
  localparam int unsigned CrcW   = 16;

  localparam logic [CrcW-1:0] CRC_INIT = 16'hFFFF;

  // configuration register indexes
  localparam logic [1:0] CFG_WAIT_RETRY_LIMIT = 2'd0;
  localparam logic [1:0] CFG_START_MARKER     = 2'd1;
  localparam logic [1:0] CFG_END_MARKER       = 2'd2;

  localparam logic [7:0] WAIT_RETRY_LIMIT_RST = 8'd10;
  localparam logic [7:0] START_MARKER_RST     = 8'h82;
  localparam logic [7:0] END_MARKER_RST       = 8'h83;

  // func codes
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_BYTE  = 1'b1;

  // status codes
  localparam logic [2:0] ST_STARTED  = 3'd0;
  localparam logic [2:0] ST_PROGRESS = 3'd1;
  localparam logic [2:0] ST_SKIPPED  = 3'd2;
  localparam logic [2:0] ST_COMPLETE = 3'd3;
  localparam logic [2:0] ST_ERROR    = 3'd4;
  localparam logic [2:0] ST_TIMEOUT  = 3'd5;
  localparam logic [2:0] ST_IGNORED  = 3'd6;

  // byte kinds
  localparam logic [3:0] KIND_NONE    = 4'd0;
  localparam logic [3:0] KIND_START   = 4'd1;
  localparam logic [3:0] KIND_SERIAL  = 4'd2;
  localparam logic [3:0] KIND_LENGTH  = 4'd3;
  localparam logic [3:0] KIND_COMMAND = 4'd4;
  localparam logic [3:0] KIND_STATUS  = 4'd5;
  localparam logic [3:0] KIND_PAYLOAD = 4'd6;
  localparam logic [3:0] KIND_CRC     = 4'd7;
  localparam logic [3:0] KIND_END     = 4'd8;

  typedef struct packed {
    logic [7:0] wait_retry_limit;
    logic [7:0] start_marker;
    logic [7:0] end_marker;
  } cfg_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [3:0]        byte_kind;
    logic [7:0]        frame_byte;
    logic [CountW-1:0] byte_count;
    logic [CrcW-1:0]   crc_value;
  } res_t;

endpackage

[rtl/ccfr_crc16.sv]
// ----------------------------------------------------------------------------
// ccfr_crc16
// One-byte update of the reflected CCITT CRC-16 (poly 0x8408).
// ----------------------------------------------------------------------------
module ccfr_crc16 (
  input  logic [ccfr_pkg::CrcW-1:0] crc_in,
  input  logic [7:0]                data,
  output logic [ccfr_pkg::CrcW-1:0] crc_out
);

  logic [7:0] d0;
  logic [7:0] d1;

  assign d0 = data ^ crc_in[7:0];
  assign d1 = d0 ^ {d0[3:0], 4'b0000};

  // table-free byte form of the shift register
  assign crc_out = {d1, crc_in[15:8]}
                 ^ {12'b0, d1[7:4]}
                 ^ {5'b0, d1, 3'b000};

endmodule

[rtl/ccfr_parser.sv]
// ----------------------------------------------------------------------------
// ccfr_parser
// Frame state machine: phase, crc, length and wait budget, one word a cycle while fire is high.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ccfr_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic                func,
  input  logic [7:0]          rx_byte,
  input  ccfr_pkg::cfg_t      cfg,
  output ccfr_pkg::res_t      res
);

  typedef enum logic [3:0] {
    PH_STX  = 4'd0,
    PH_SNR0 = 4'd1,
    PH_SNR1 = 4'd2,
    PH_SNR2 = 4'd3,
    PH_SNR3 = 4'd4,
    PH_LEN0 = 4'd5,
    PH_LEN1 = 4'd6,
    PH_CMD  = 4'd7,
    PH_STAT = 4'd8,
    PH_DATA = 4'd9,
    PH_CRC0 = 4'd10,
    PH_CRC1 = 4'd11,
    PH_ETX  = 4'd12,
    PH_DONE = 4'd13,
    PH_ERR  = 4'd14,
    PH_TOUT = 4'd15
  } phase_t;

  phase_t                          phase, phase_next;
  logic [ccfr_pkg::CrcW-1:0]       crc_accum, crc_accum_next;
  logic [7:0]                      bytes_left, bytes_left_next;
  logic [7:0]                      wait_left, wait_left_next;
  logic [ccfr_pkg::CountW-1:0]     accepted_count, accepted_count_next;
  logic [ccfr_pkg::CrcW-1:0]       crc_upd;
  logic [7:0]                      dec_left;

  ccfr_crc16 u_crc (
    .crc_in  (crc_accum),
    .data    (rx_byte),
    .crc_out (crc_upd)
  );

  assign dec_left = bytes_left - 8'd1;

  always_comb begin
    phase_next          = phase;
    crc_accum_next      = crc_accum;
    bytes_left_next     = bytes_left;
    wait_left_next      = wait_left;
    accepted_count_next = accepted_count;
    res.status          = ccfr_pkg::ST_IGNORED;
    res.byte_kind       = ccfr_pkg::KIND_NONE;
    res.frame_byte      = 8'h00;

    if (func == ccfr_pkg::FUNC_START) begin
      phase_next          = PH_STX;
      crc_accum_next      = ccfr_pkg::CRC_INIT;
      bytes_left_next     = 8'h00;
      wait_left_next      = cfg.wait_retry_limit;
      accepted_count_next = '0;
      res.status          = ccfr_pkg::ST_STARTED;
    end else if (phase inside {PH_DONE, PH_ERR, PH_TOUT}) begin
      res.status = ccfr_pkg::ST_IGNORED;
    end else if (rx_byte == 8'h00 && wait_left != 8'h00) begin
      // leading zero eats one unit of the wait budget
      wait_left_next = wait_left - 8'd1;
      if (wait_left == 8'd1) begin
        phase_next = PH_TOUT;
        res.status = ccfr_pkg::ST_TIMEOUT;
      end else begin
        res.status = ccfr_pkg::ST_SKIPPED;
      end
    end else begin
      wait_left_next      = 8'h00;
      accepted_count_next = accepted_count + 9'd1;
      res.frame_byte      = rx_byte;
      if (phase inside {[PH_SNR0:PH_DATA]}) begin
        crc_accum_next = crc_upd;
      end
      case (phase)
        PH_STX: begin
          crc_accum_next = ccfr_pkg::CRC_INIT;
          res.byte_kind  = ccfr_pkg::KIND_START;
          phase_next     = (rx_byte == cfg.start_marker) ? PH_SNR0 : PH_ERR;
        end
        PH_SNR0: begin
          res.byte_kind = ccfr_pkg::KIND_SERIAL;
          phase_next    = PH_SNR1;
        end
        PH_SNR1: begin
          res.byte_kind = ccfr_pkg::KIND_SERIAL;
          phase_next    = PH_SNR2;
        end
        PH_SNR2: begin
          res.byte_kind = ccfr_pkg::KIND_SERIAL;
          phase_next    = PH_SNR3;
        end
        PH_SNR3: begin
          res.byte_kind = ccfr_pkg::KIND_SERIAL;
          phase_next    = PH_LEN0;
        end
        PH_LEN0: begin
          res.byte_kind = ccfr_pkg::KIND_LENGTH;
          phase_next    = (rx_byte == 8'h00) ? PH_LEN1 : PH_ERR;
        end
        PH_LEN1: begin
          res.byte_kind   = ccfr_pkg::KIND_LENGTH;
          bytes_left_next = rx_byte;
          phase_next      = (rx_byte >= 8'd2) ? PH_CMD : PH_ERR;
        end
        PH_CMD: begin
          res.byte_kind   = ccfr_pkg::KIND_COMMAND;
          bytes_left_next = dec_left;
          phase_next      = PH_STAT;
        end
        PH_STAT, PH_DATA: begin
          res.byte_kind   = (phase == PH_STAT) ? ccfr_pkg::KIND_STATUS
                                               : ccfr_pkg::KIND_PAYLOAD;
          bytes_left_next = dec_left;
          phase_next      = (dec_left == 8'h00) ? PH_CRC0 : PH_DATA;
        end
        PH_CRC0: begin
          res.byte_kind = ccfr_pkg::KIND_CRC;
          phase_next    = (rx_byte == crc_accum[15:8]) ? PH_CRC1 : PH_ERR;
        end
        PH_CRC1: begin
          res.byte_kind = ccfr_pkg::KIND_CRC;
          phase_next    = (rx_byte == crc_accum[7:0]) ? PH_ETX : PH_ERR;
        end
        PH_ETX: begin
          res.byte_kind = ccfr_pkg::KIND_END;
          phase_next    = (rx_byte == cfg.end_marker) ? PH_DONE : PH_ERR;
        end
        default: begin
          phase_next = PH_ERR;
        end
      endcase
      if (phase_next == PH_DONE) begin
        res.status = ccfr_pkg::ST_COMPLETE;
      end else if (phase_next == PH_ERR) begin
        res.status = ccfr_pkg::ST_ERROR;
      end else begin
        res.status = ccfr_pkg::ST_PROGRESS;
      end
    end

    res.byte_count = accepted_count_next;
    res.crc_value  = crc_accum_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_STX;
      crc_accum      <= ccfr_pkg::CRC_INIT;
      bytes_left     <= 8'h00;
      wait_left      <= ccfr_pkg::WAIT_RETRY_LIMIT_RST;
      accepted_count <= '0;
    end else if (fire) begin
      phase          <= phase_next;
      crc_accum      <= crc_accum_next;
      bytes_left     <= bytes_left_next;
      wait_left      <= wait_left_next;
      accepted_count <= accepted_count_next;
    end
  end

  // budget only lives while the start marker is awaited
  `ASSERT_SAME(a_wait_only_idle, clk, rst, wait_left != 8'h00, phase == PH_STX,
               "wait budget left outside start phase")

  `ASSERT_NEXT(a_start_clears, clk, rst, fire && func == ccfr_pkg::FUNC_START,
               accepted_count == '0 && crc_accum == ccfr_pkg::CRC_INIT,
               "start word did not clear the receiver")

  `ASSERT_NEXT(a_sticky_hold, clk, rst,
               fire && func == ccfr_pkg::FUNC_BYTE &&
               (phase == PH_DONE || phase == PH_ERR || phase == PH_TOUT),
               $stable(accepted_count) && $stable(crc_accum) && $stable(phase),
               "finished receiver changed state")

  `ASSERT_NEXT(a_count_step, clk, rst, fire,
               accepted_count == $past(accepted_count) ||
               accepted_count == 9'($past(accepted_count) + 9'd1) ||
               accepted_count == '0,
               "byte count jumped")

endmodule

[rtl/ccfr_out_stage.sv]
// ----------------------------------------------------------------------------
// ccfr_out_stage
// Result register with valid flag; holds off the input side while a word waits.
// ----------------------------------------------------------------------------
module ccfr_out_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  ccfr_pkg::res_t res,
  output logic           ready,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [39:0]    m_tdata,
  output logic [6:0]     m_tuser
);

  ccfr_pkg::res_t held;
  logic           valid;

  // room for a new word when empty or when the held one leaves now
  assign ready    = !valid || m_tready;
  assign m_tvalid = valid;
  assign m_tdata  = {7'b0, held.crc_value, held.byte_count, held.frame_byte};
  assign m_tuser  = {held.byte_kind, held.status};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (m_tready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

endmodule

[rtl/crc_checked_frame_receiver.sv]
// ----------------------------------------------------------------------------
// crc_checked_frame_receiver
// Reply frame receiver with layout check and CRC-16 check.
// ----------------------------------------------------------------------------
// Each input word gives exactly one result word, registered and shown in the cycle after it is taken.
// A word can be taken every cycle: the frame state machine and the byte-wide
// CRC update sit in front of a single result register, and s_tready drops
// only while that register is full and m_tready is low. A start word
// (func 0) restarts reception; completion, error and timeout hold until the
// next start word. Configuration writes are taken at any edge with cfg_we
// high; a new wait limit applies from the next start word.
module crc_checked_frame_receiver (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_byte[7:0]
  input  logic        s_tuser,   // func[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // frame_byte[7:0], byte_count[16:8], crc_value[32:17]
  output logic [6:0]  m_tuser,   // status[2:0], byte_kind[6:3]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  ccfr_pkg::cfg_t cfg;
  ccfr_pkg::res_t res;
  logic           fire;

  assign fire = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wait_retry_limit <= ccfr_pkg::WAIT_RETRY_LIMIT_RST;
      cfg.start_marker     <= ccfr_pkg::START_MARKER_RST;
      cfg.end_marker       <= ccfr_pkg::END_MARKER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ccfr_pkg::CFG_WAIT_RETRY_LIMIT: cfg.wait_retry_limit <= cfg_data;
        ccfr_pkg::CFG_START_MARKER:     cfg.start_marker     <= cfg_data;
        ccfr_pkg::CFG_END_MARKER:       cfg.end_marker       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  ccfr_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .func    (s_tuser),
    .rx_byte (s_tdata),
    .cfg     (cfg),
    .res     (res)
  );

  ccfr_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (fire),
    .res      (res),
    .ready    (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

[verif/tb_crc_checked_frame_receiver.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_crc_checked_frame_receiver
// Self-checking bench for the CRC-checked reply frame receiver. Start words,
// well-formed and damaged frames, leading-zero timeouts and noise are streamed
// in under random sender bursts and receiver stalls; every reply word is
// checked against a cycle-free prediction of the receiver, across several
// marker and wait-limit settings.
// ----------------------------------------------------------------------------
module tb_crc_checked_frame_receiver;

  localparam int WORD_TARGET = 1600;
  localparam int PHASE_WORDS = 200;
  localparam int HOLD_CYCLES = 150;
  localparam int IDLE_LIMIT  = 5000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic [6:0]  m_tuser;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;

  crc_checked_frame_receiver DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  typedef enum logic [3:0] {
    AT_START, AT_SERIAL0, AT_SERIAL1, AT_SERIAL2, AT_SERIAL3, AT_LEN_HI, AT_LEN_LO,
    AT_COMMAND, AT_STATUS, AT_PAYLOAD, AT_CRC_HI, AT_CRC_LO, AT_END,
    AT_DONE, AT_ERROR, AT_TIMEOUT
  } rx_at_e;

  typedef enum int {PACE_FREE, PACE_RANDOM, PACE_PERIODIC, PACE_RUNS} pace_e;

  typedef logic [7:0] byte_q_t[$];

  class reply_scoreboard;
    ccfr_pkg::cfg_t regs;
    rx_at_e         at;
    logic [15:0]    crc;
    logic [7:0]     len_left;
    logic [7:0]     wait_left;
    logic [8:0]     taken;
    ccfr_pkg::res_t pending[$];
    int             failures;
    int             words_fed;
    int             live_words;
    int             replies;
    int             completes;
    int             errors;
    int             timeouts;

    function new();
      regs.wait_retry_limit = ccfr_pkg::WAIT_RETRY_LIMIT_RST;
      regs.start_marker     = ccfr_pkg::START_MARKER_RST;
      regs.end_marker       = ccfr_pkg::END_MARKER_RST;
      restart();
      failures   = 0;
      words_fed  = 0;
      live_words = 0;
      replies    = 0;
      completes  = 0;
      errors     = 0;
      timeouts   = 0;
    endfunction

    function void restart();
      at        = AT_START;
      crc       = ccfr_pkg::CRC_INIT;
      len_left  = 8'h00;
      wait_left = regs.wait_retry_limit;
      taken     = '0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        ccfr_pkg::CFG_WAIT_RETRY_LIMIT: regs.wait_retry_limit = val;
        ccfr_pkg::CFG_START_MARKER:     regs.start_marker = val;
        ccfr_pkg::CFG_END_MARKER:       regs.end_marker = val;
        default: ;
      endcase
    endfunction

    // reflected ccitt, lsb first
    function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      r = c ^ {8'h00, b};
      for (int i = 0; i < 8; i++) r = r[0] ? ((r >> 1) ^ 16'h8408) : (r >> 1);
      return r;
    endfunction

    function void note_word(logic func, logic [7:0] b);
      ccfr_pkg::res_t r;
      rx_at_e         nxt;
      r.status     = ccfr_pkg::ST_PROGRESS;
      r.byte_kind  = ccfr_pkg::KIND_NONE;
      r.frame_byte = 8'h00;
      words_fed++;
      if (func == ccfr_pkg::FUNC_START) begin
        restart();
        r.status = ccfr_pkg::ST_STARTED;
      end else if (at == AT_DONE || at == AT_ERROR || at == AT_TIMEOUT) begin
        r.status = ccfr_pkg::ST_IGNORED;
      end else if (b == 8'h00 && wait_left != 8'h00) begin
        wait_left--;
        if (wait_left == 8'h00) begin
          at = AT_TIMEOUT;
          r.status = ccfr_pkg::ST_TIMEOUT;
          timeouts++;
        end else begin
          r.status = ccfr_pkg::ST_SKIPPED;
        end
      end else begin
        wait_left    = 8'h00;
        taken        = taken + 9'd1;
        r.frame_byte = b;
        nxt          = AT_ERROR;
        if (at >= AT_SERIAL0 && at <= AT_PAYLOAD) crc = crc_step(crc, b);
        case (at)
          AT_START: begin
            crc = ccfr_pkg::CRC_INIT;
            r.byte_kind = ccfr_pkg::KIND_START;
            if (b == regs.start_marker) nxt = AT_SERIAL0;
          end
          AT_SERIAL0, AT_SERIAL1, AT_SERIAL2, AT_SERIAL3: begin
            r.byte_kind = ccfr_pkg::KIND_SERIAL;
            nxt = rx_at_e'(at + 1);
          end
          AT_LEN_HI: begin
            r.byte_kind = ccfr_pkg::KIND_LENGTH;
            if (b == 8'h00) nxt = AT_LEN_LO;
          end
          AT_LEN_LO: begin
            r.byte_kind = ccfr_pkg::KIND_LENGTH;
            len_left = b;
            if (b >= 8'd2) nxt = AT_COMMAND;
          end
          AT_COMMAND: begin
            r.byte_kind = ccfr_pkg::KIND_COMMAND;
            len_left--;
            nxt = AT_STATUS;
          end
          AT_STATUS, AT_PAYLOAD: begin
            r.byte_kind = (at == AT_STATUS) ? ccfr_pkg::KIND_STATUS
                                            : ccfr_pkg::KIND_PAYLOAD;
            len_left--;
            nxt = (len_left == 8'h00) ? AT_CRC_HI : AT_PAYLOAD;
          end
          AT_CRC_HI: begin
            r.byte_kind = ccfr_pkg::KIND_CRC;
            if (b == crc[15:8]) nxt = AT_CRC_LO;
          end
          AT_CRC_LO: begin
            r.byte_kind = ccfr_pkg::KIND_CRC;
            if (b == crc[7:0]) nxt = AT_END;
          end
          AT_END: begin
            r.byte_kind = ccfr_pkg::KIND_END;
            if (b == regs.end_marker) nxt = AT_DONE;
          end
          default: ;
        endcase
        at = nxt;
        if (nxt == AT_DONE) begin
          r.status = ccfr_pkg::ST_COMPLETE;
          completes++;
        end else if (nxt == AT_ERROR) begin
          r.status = ccfr_pkg::ST_ERROR;
          errors++;
        end
      end
      if (r.status != ccfr_pkg::ST_IGNORED) live_words++;
      r.byte_count = taken;
      r.crc_value  = crc;
      pending.push_back(r);
    endfunction

    function void check_reply(ccfr_pkg::res_t got);
      ccfr_pkg::res_t want;
      replies++;
      if (pending.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected reply: st=%0d kind=%0d byte=%02h count=%0d crc=%04h",
                   got.status, got.byte_kind, got.frame_byte, got.byte_count,
                   got.crc_value);
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status || got.byte_kind !== want.byte_kind ||
          got.frame_byte !== want.frame_byte || got.byte_count !== want.byte_count ||
          got.crc_value !== want.crc_value) begin
        failures++;
        if (failures <= 10) begin
          $display("reply %0d mismatch: want st=%0d kind=%0d byte=%02h count=%0d crc=%04h",
                   replies, want.status, want.byte_kind, want.frame_byte,
                   want.byte_count, want.crc_value);
          $display("  got st=%0d kind=%0d byte=%02h count=%0d crc=%04h",
                   got.status, got.byte_kind, got.frame_byte, got.byte_count,
                   got.crc_value);
        end
      end
    endfunction
  endclass

  reply_scoreboard sb;
  int burst_left = 0;
  int idle_cycles = 0;
  int holds_done = 0;
  int settings_used = 0;
  bit hold_req = 1'b0;
  bit long_tout_done = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin : reply_mon
    ccfr_pkg::res_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.frame_byte = m_tdata[7:0];
      got.byte_count = m_tdata[16:8];
      got.crc_value  = m_tdata[32:17];
      got.status     = m_tuser[2:0];
      got.byte_kind  = m_tuser[6:3];
      sb.check_reply(got);
    end
  end

  always @(posedge clk) begin : watchdog
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("no word moved for %0d cycles", IDLE_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  // reply side pacing, with an occasional long hold-off on request
  initial begin : sink_pace
    pace_e mode;
    int    span;
    int    tick;
    int    hold_left;
    mode      = PACE_FREE;
    span      = 1;
    tick      = 0;
    hold_left = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        holds_done++;
        m_tready <= 1'b0;
      end else begin
        span--;
        if (span <= 0) begin
          mode = pace_e'($urandom_range(0, 3));
          span = $urandom_range(20, 300);
          tick = 0;
        end
        tick++;
        case (mode)
          PACE_FREE:     m_tready <= 1'b1;
          PACE_RANDOM:   m_tready <= ($urandom_range(0, 99) >= 35);
          PACE_PERIODIC: m_tready <= ((tick % 5) != 0);
          default:       m_tready <= (((tick / 7) % 2) == 0);
        endcase
      end
    end
  end

  function automatic logic [7:0] rand_byte();
    int p;
    p = $urandom_range(0, 9);
    return (p == 0) ? 8'h00 : (p == 1) ? 8'hFF : 8'($urandom_range(0, 255));
  endfunction

  // start marker .. end marker, crc over serial through payload
  function automatic byte_q_t build_frame(int plen);
    byte_q_t     q;
    logic [15:0] c;
    q.push_back(sb.regs.start_marker);
    repeat (4) q.push_back(rand_byte());
    q.push_back(8'h00);
    q.push_back(8'(plen));
    repeat (plen) q.push_back(rand_byte());
    c = ccfr_pkg::CRC_INIT;
    for (int i = 1; i < q.size(); i++) c = sb.crc_step(c, q[i]);
    q.push_back(c[15:8]);
    q.push_back(c[7:0]);
    q.push_back(sb.regs.end_marker);
    return q;
  endfunction

  task automatic send_word(input logic func, input logic [7:0] b);
    int gap;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if ($urandom_range(0, 19) == 0) gap = $urandom_range(15, 40);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    sb.note_word(func, b);
  endtask

  // stop offering and wait for every outstanding reply
  task automatic settle();
    s_tvalid  <= 1'b0;
    burst_left = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_regs(input logic [7:0] lim, input logic [7:0] smk,
                            input logic [7:0] emk);
    cfg_we    <= 1'b1;
    cfg_index <= ccfr_pkg::CFG_WAIT_RETRY_LIMIT;
    cfg_data  <= lim;
    @(posedge clk);
    sb.write_reg(ccfr_pkg::CFG_WAIT_RETRY_LIMIT, lim);
    cfg_index <= ccfr_pkg::CFG_START_MARKER;
    cfg_data  <= smk;
    @(posedge clk);
    sb.write_reg(ccfr_pkg::CFG_START_MARKER, smk);
    cfg_index <= ccfr_pkg::CFG_END_MARKER;
    cfg_data  <= emk;
    @(posedge clk);
    sb.write_reg(ccfr_pkg::CFG_END_MARKER, emk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic send_frame();
    byte_q_t q;
    int      pick;
    int      plen;
    int      cut;
    int      zeros;
    pick = $urandom_range(0, 99);
    plen = (pick < 88) ? $urandom_range(2, 8) :
           (pick < 98) ? $urandom_range(9, 40) : $urandom_range(41, 255);
    q = build_frame(plen);
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      cut = $urandom_range(0, q.size() - 1);
      q[cut] ^= 8'($urandom_range(1, 255));
    end else if (pick < 16) begin
      q[6] = 8'($urandom_range(0, 1));        // length below two
    end else if (pick < 18) begin
      q[5] = 8'($urandom_range(1, 255));      // length high nonzero
    end
    cut = ($urandom_range(0, 99) < 8) ? $urandom_range(1, q.size() - 1) : q.size();
    if ($urandom_range(0, 19) != 0) begin
      send_word(ccfr_pkg::FUNC_START, rand_byte());
      zeros = 0;
      if (sb.regs.wait_retry_limit > 8'd1)
        zeros = $urandom_range(0, (sb.regs.wait_retry_limit > 8'd6) ? 5
                                  : sb.regs.wait_retry_limit - 1);
      repeat (zeros) send_word(ccfr_pkg::FUNC_BYTE, 8'h00);
    end
    for (int i = 0; i < cut; i++) send_word(ccfr_pkg::FUNC_BYTE, q[i]);
    repeat ($urandom_range(0, 2)) send_word(ccfr_pkg::FUNC_BYTE, rand_byte());
  endtask

  task automatic send_timeout();
    int lim;
    lim = sb.regs.wait_retry_limit;
    if (lim == 0 || (lim > 40 && long_tout_done)) return;
    if (lim > 40) long_tout_done = 1'b1;
    send_word(ccfr_pkg::FUNC_START, rand_byte());
    repeat (lim) send_word(ccfr_pkg::FUNC_BYTE, 8'h00);
    repeat ($urandom_range(0, 2)) send_word(ccfr_pkg::FUNC_BYTE, rand_byte());
  endtask

  initial begin : stimulus
    byte_q_t    q;
    int         ph;
    int         phase_end;
    int         pick;
    logic [7:0] lim;
    logic [7:0] smk;
    logic [7:0] emk;
    sb = new();
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= 8'h00;
    s_tuser   <= ccfr_pkg::FUNC_START;
    cfg_we    <= 1'b0;
    cfg_index <= ccfr_pkg::CFG_WAIT_RETRY_LIMIT;
    cfg_data  <= 8'h00;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // shortest frame at reset settings, framed by a skipped zero and an ignored word
    send_word(ccfr_pkg::FUNC_START, 8'hFF);
    send_word(ccfr_pkg::FUNC_BYTE, 8'h00);
    q = build_frame(2);
    foreach (q[i]) send_word(ccfr_pkg::FUNC_BYTE, q[i]);
    send_word(ccfr_pkg::FUNC_BYTE, 8'hFF);

    // no wait budget: a zero is taken as the start marker
    settle();
    write_regs(8'd0, 8'h00, 8'hFF);
    send_word(ccfr_pkg::FUNC_START, 8'h00);
    send_word(ccfr_pkg::FUNC_BYTE, 8'h00);
    send_word(ccfr_pkg::FUNC_BYTE, 8'h7F);

    // budget of one runs out on the first zero, then a bad start marker
    settle();
    write_regs(8'd1, ccfr_pkg::START_MARKER_RST, ccfr_pkg::END_MARKER_RST);
    send_word(ccfr_pkg::FUNC_START, 8'h5A);
    send_word(ccfr_pkg::FUNC_BYTE, 8'h00);
    send_word(ccfr_pkg::FUNC_BYTE, 8'hAB);
    send_word(ccfr_pkg::FUNC_START, 8'hA5);
    send_word(ccfr_pkg::FUNC_BYTE, 8'h7E);

    for (ph = 0; sb.words_fed < WORD_TARGET; ph++) begin
      case (ph)
        0: begin
          lim = ccfr_pkg::WAIT_RETRY_LIMIT_RST;
          smk = ccfr_pkg::START_MARKER_RST;
          emk = ccfr_pkg::END_MARKER_RST;
        end
        1: begin lim = 8'd0;   smk = 8'h00; emk = 8'hFF; end
        2: begin lim = 8'd255; smk = 8'hFF; emk = 8'h00; end
        3: begin lim = 8'd1;   smk = 8'($urandom_range(1, 255)); emk = rand_byte(); end
        4: begin
          lim = 8'($urandom_range(2, 20));
          smk = 8'($urandom_range(1, 255));
          emk = rand_byte();
        end
        5: begin
          lim = 8'd3;
          smk = ccfr_pkg::START_MARKER_RST;
          emk = ccfr_pkg::END_MARKER_RST;
        end
        default: begin
          pick = $urandom_range(0, 9);
          lim  = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom_range(1, 30));
          smk  = (lim == 8'd0) ? rand_byte() : 8'($urandom_range(1, 255));
          emk  = rand_byte();
        end
      endcase
      settle();
      write_regs(lim, smk, emk);
      // long reply stall while the sender keeps pushing
      if (ph == 1 || ph == 4) hold_req = 1'b1;
      phase_end = sb.words_fed + PHASE_WORDS;
      while (sb.words_fed < phase_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
          repeat ($urandom_range(1, 6))
            send_word(($urandom_range(0, 9) == 0) ? ccfr_pkg::FUNC_START
                                                  : ccfr_pkg::FUNC_BYTE, rand_byte());
        end else if (pick < 12) begin
          send_timeout();
        end else begin
          send_frame();
        end
      end
    end

    settle();
    repeat (5) @(posedge clk);
    $display("fed %0d words (%0d live) over %0d register settings, %0d long reply stalls",
             sb.words_fed, sb.live_words, settings_used, holds_done);
    $display("frames: %0d complete, %0d errored, %0d timed out; %0d replies checked",
             sb.completes, sb.errors, sb.timeouts, sb.replies);
    if (sb.pending.size() != 0)
      $display("%0d replies never arrived", sb.pending.size());
    if (sb.failures == 0 && sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
